[src/srcs_pkg.sv]
// shared types and constants of the sparse row store
package srcs_pkg;

    localparam int COL_W = 10;
    localparam int ROW_W = 10;
    localparam int VAL_W = 32;
    localparam int DIM_W = 11;

    typedef enum logic {
        OP_READ,
        OP_WRITE
    } t_op;

    typedef enum logic {
        CFG_NUM_ROWS,
        CFG_NUM_COLS
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_BOUND = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_PUT,
        ST_DL_RD,
        ST_DL_WR,
        ST_OWN_WR,
        ST_LATER_RD,
        ST_LATER_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op               op;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [VAL_W-1:0]  val;
    } t_request;

    typedef struct packed {
        logic [VAL_W-1:0]  read_value;
        t_status           status;
        logic              new_entry;
    } t_result;

endpackage

[src/sparse_row_compressed_store_core.sv]
// Sparse integer matrix store in compressed row form, one element read or write per request.
// The block is ready for a request only when the previous one is finished. After reset a
// clearing pass writes every row of the row table before the first request is taken.
// A read looks up the row and scans its entries in column order. An insert or delete also
// moves each later entry in the entry ram by one slot and rewrites the row table word of
// every row after the addressed row (MAX_DIM - row - 1 rows). The row table and entry ram
// are single port, each touched once per cycle.
module sparse_row_compressed_store_core
    import srcs_pkg::*;
#(
    parameter int ENTRY_CAPACITY = 1024,
    parameter int MAX_DIM        = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [55:0]              s_axis_tdata,  // row_index[9:0], col_index[19:10], write_value[51:20], zero
    input  logic                     s_axis_tuser,  // op
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [31:0]              m_axis_tdata,  // read_value
    output logic [2:0]               m_axis_tuser,  // status[1:0], new_entry[2]
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [DIM_W-1:0]         i_cfg_data
);

    localparam int EW = $clog2(ENTRY_CAPACITY);
    localparam int CW = $clog2(ENTRY_CAPACITY + 1);
    localparam int RW = $clog2(MAX_DIM);

    logic [DIM_W-1:0]        r_num_rows;
    logic [DIM_W-1:0]        r_num_cols;
    logic                    r_out_valid;
    t_result                 r_out;

    t_request                req;
    t_result                 res;
    logic                    res_valid;
    logic                    res_free;
    logic [RW-1:0]           row_addr;
    logic                    row_we;
    logic [2*CW-1:0]         row_wdata;
    logic [2*CW-1:0]         row_rdata;
    logic [EW-1:0]           ent_addr;
    logic                    ent_we;
    logic [COL_W+VAL_W-1:0]  ent_wdata;
    logic [COL_W+VAL_W-1:0]  ent_rdata;

    assign req.op  = t_op'(s_axis_tuser);
    assign req.row = s_axis_tdata[9:0];
    assign req.col = s_axis_tdata[19:10];
    assign req.val = s_axis_tdata[51:20];

    assign res_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= DIM_W'(1024);
            r_num_cols <= DIM_W'(1024);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register parts the sequencer from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_free) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.read_value;
    assign m_axis_tuser  = {r_out.new_entry, r_out.status};

    srcs_ram #(
        .DEPTH (MAX_DIM),
        .WIDTH (2*CW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_addr  (row_addr),
        .i_we    (row_we),
        .i_wdata (row_wdata),
        .o_rdata (row_rdata)
    );

    srcs_ram #(
        .DEPTH (ENTRY_CAPACITY),
        .WIDTH (COL_W+VAL_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_addr  (ent_addr),
        .i_we    (ent_we),
        .i_wdata (ent_wdata),
        .o_rdata (ent_rdata)
    );

    srcs_ctrl #(
        .ENTRY_CAPACITY (ENTRY_CAPACITY),
        .MAX_DIM        (MAX_DIM)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .i_num_rows  (r_num_rows),
        .i_num_cols  (r_num_cols),
        .o_row_addr  (row_addr),
        .o_row_we    (row_we),
        .o_row_wdata (row_wdata),
        .i_row_rdata (row_rdata),
        .o_ent_addr  (ent_addr),
        .o_ent_we    (ent_we),
        .o_ent_wdata (ent_wdata),
        .i_ent_rdata (ent_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_free),
        .o_res       (res)
    );

    // one request at a time: ready drops right after a beat is taken
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] != 2'd3))
        else $error("undefined status code");

    a_new_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
            (m_axis_tuser[1:0] == STAT_OK && m_axis_tdata == '0))
        else $error("insert flagged with error or read data");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !s_axis_tready)
        else $error("result pending while accepting");

endmodule

[src/srcs_ram.sv]
// single port synchronous ram with registered read data
module srcs_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/srcs_ctrl.sv]
// sequencer: row table clearing, row lookup, entry scan, shifts and row offset updates
module srcs_ctrl
    import srcs_pkg::*;
#(
    parameter int ENTRY_CAPACITY = 1024,
    parameter int MAX_DIM        = 1024,
    localparam int EW = $clog2(ENTRY_CAPACITY),
    localparam int CW = $clog2(ENTRY_CAPACITY + 1),
    localparam int RW = $clog2(MAX_DIM)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_request             i_req,
    input  logic [DIM_W-1:0]     i_num_rows,
    input  logic [DIM_W-1:0]     i_num_cols,
    output logic [RW-1:0]        o_row_addr,
    output logic                 o_row_we,
    output logic [2*CW-1:0]      o_row_wdata,
    input  logic [2*CW-1:0]      i_row_rdata,
    output logic [EW-1:0]        o_ent_addr,
    output logic                 o_ent_we,
    output logic [COL_W+VAL_W-1:0] o_ent_wdata,
    input  logic [COL_W+VAL_W-1:0] i_ent_rdata,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    t_state            r_state, n_state;
    t_request          r_req, n_req;
    t_result           r_res, n_res;
    logic [CW-1:0]     r_base, n_base;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_s, n_s;
    logic [CW-1:0]     r_total, n_total;
    logic              r_found, n_found;
    logic [VAL_W-1:0]  r_value, n_value;
    logic [RW-1:0]     r_r, n_r;
    logic [RW-1:0]     r_clr, n_clr;

    logic [CW-1:0]     scan_slot;
    logic [COL_W-1:0]  ent_col;
    logic [VAL_W-1:0]  ent_val;
    logic [CW-1:0]     rd_start;
    logic [CW-1:0]     rd_count;
    logic              oob;
    logic              ins;
    logic              last_row;
    logic              own_last;

    assign scan_slot = r_base + r_k;
    assign ent_col   = i_ent_rdata[VAL_W +: COL_W];
    assign ent_val   = i_ent_rdata[VAL_W-1:0];
    assign rd_start  = i_row_rdata[2*CW-1:CW];
    assign rd_count  = i_row_rdata[CW-1:0];
    assign oob = ({1'b0, i_req.row} >= i_num_rows) || ({1'b0, i_req.col} >= i_num_cols)
              || (32'(i_req.row) >= MAX_DIM);
    assign ins       = (r_req.val != '0);
    assign last_row  = (r_r == RW'(MAX_DIM - 1));
    assign own_last  = (RW'(r_req.row) == RW'(MAX_DIM - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == RW'(MAX_DIM - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req_valid) n_state = oob ? ST_DONE : ST_ROW;
            end
            ST_ROW: begin
                n_state = (rd_count == '0) ? ST_DECIDE : ST_SCAN_RD;
            end
            ST_SCAN_RD: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                // columns are sorted within a row, so stop at the first one not below
                if (ent_col >= r_req.col || (r_k + 1'b1) == r_count) n_state = ST_DECIDE;
                else n_state = ST_SCAN_RD;
            end
            ST_DECIDE: begin
                if (r_req.op == OP_READ) begin
                    n_state = ST_DONE;
                end else if (r_found) begin
                    if (ins) n_state = ST_DONE;
                    else if ((r_s + 1'b1) < r_total) n_state = ST_DL_RD;
                    else n_state = ST_OWN_WR;
                end else if (!ins) begin
                    n_state = ST_DONE;
                end else if (r_total == CW'(ENTRY_CAPACITY)) begin
                    n_state = ST_DONE;
                end else if (r_total == r_pos) begin
                    n_state = ST_INS_PUT;
                end else begin
                    n_state = ST_SH_RD;
                end
            end
            ST_SH_RD: n_state = ST_SH_WR;
            ST_SH_WR: n_state = ((r_s - 1'b1) == r_pos) ? ST_INS_PUT : ST_SH_RD;
            ST_INS_PUT: n_state = ST_OWN_WR;
            ST_DL_RD: n_state = ST_DL_WR;
            ST_DL_WR: n_state = ((r_s + 2'd2) < r_total) ? ST_DL_RD : ST_OWN_WR;
            ST_OWN_WR: n_state = own_last ? ST_DONE : ST_LATER_RD;
            ST_LATER_RD: n_state = ST_LATER_WR;
            ST_LATER_WR: n_state = last_row ? ST_DONE : ST_LATER_RD;
            ST_DONE: begin
                if (i_res_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_req   = r_req;
        n_res   = r_res;
        n_base  = r_base;
        n_count = r_count;
        n_k     = r_k;
        n_pos   = r_pos;
        n_s     = r_s;
        n_total = r_total;
        n_found = r_found;
        n_value = r_value;
        n_r     = r_r;
        n_clr   = r_clr;
        case (r_state)
            ST_CLEAR: n_clr = r_clr + 1'b1;
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_req             = i_req;
                    n_res.read_value  = '0;
                    n_res.status      = oob ? STAT_BOUND : STAT_OK;
                    n_res.new_entry   = 1'b0;
                    n_found           = 1'b0;
                end
            end
            ST_ROW: begin
                n_base  = rd_start;
                n_count = rd_count;
                n_pos   = rd_start;
                n_k     = '0;
            end
            ST_SCAN_CHK: begin
                if (ent_col == r_req.col) begin
                    n_found = 1'b1;
                    n_s     = scan_slot;
                    n_value = ent_val;
                end else if (ent_col < r_req.col) begin
                    n_pos = scan_slot + 1'b1;
                    n_k   = r_k + 1'b1;
                end
            end
            ST_DECIDE: begin
                if (r_req.op == OP_READ) begin
                    n_res.read_value = r_found ? r_value : '0;
                end else if (!r_found && ins) begin
                    if (r_total == CW'(ENTRY_CAPACITY)) n_res.status = STAT_FULL;
                    else n_s = r_total;
                end
            end
            ST_SH_WR: n_s = r_s - 1'b1;
            ST_INS_PUT: n_res.new_entry = 1'b1;
            ST_DL_WR: n_s = r_s + 1'b1;
            ST_OWN_WR: begin
                n_total = ins ? r_total + 1'b1 : r_total - 1'b1;
                n_r     = RW'(r_req.row) + 1'b1;
            end
            ST_LATER_WR: n_r = r_r + 1'b1;
            default: ;
        endcase
    end

    // memory ports and handshakes
    always_comb begin
        o_row_addr  = r_r;
        o_row_we    = 1'b0;
        o_row_wdata = '0;
        o_ent_addr  = EW'(scan_slot);
        o_ent_we    = 1'b0;
        o_ent_wdata = {r_req.col, r_req.val};
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_row_addr = r_clr;
                o_row_we   = 1'b1;
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_row_addr  = RW'(i_req.row);
            end
            ST_DECIDE: begin
                o_ent_addr = EW'(r_s);
                o_ent_we   = (r_req.op == OP_WRITE) && r_found && ins;
            end
            ST_SH_RD: o_ent_addr = EW'(r_s - 1'b1);
            ST_SH_WR: begin
                o_ent_addr  = EW'(r_s);
                o_ent_we    = 1'b1;
                o_ent_wdata = i_ent_rdata;
            end
            ST_INS_PUT: begin
                o_ent_addr = EW'(r_pos);
                o_ent_we   = 1'b1;
            end
            ST_DL_RD: o_ent_addr = EW'(r_s + 1'b1);
            ST_DL_WR: begin
                o_ent_addr  = EW'(r_s);
                o_ent_we    = 1'b1;
                o_ent_wdata = i_ent_rdata;
            end
            ST_OWN_WR: begin
                o_row_addr  = RW'(r_req.row);
                o_row_we    = 1'b1;
                o_row_wdata = {r_base, ins ? r_count + 1'b1 : r_count - 1'b1};
            end
            ST_LATER_WR: begin
                // read data still holds the row fetched in the previous beat
                o_row_we    = 1'b1;
                o_row_wdata = {ins ? rd_start + 1'b1 : rd_start - 1'b1, rd_count};
            end
            ST_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_total <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_res   <= n_res;
        r_base  <= n_base;
        r_count <= n_count;
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_s     <= n_s;
        r_found <= n_found;
        r_value <= n_value;
        r_r     <= n_r;
    end

endmodule
